/* hw/rtl/cbq_pkg.sv */
// Shared widths, codes, control struct and saturation helpers of the biquad filter.
package cbq_pkg;

    // Audio sample width and fraction bits of the coefficients.
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;

    // Coefficient, delay, product and sum widths.
    localparam int COEF_W  = 32;
    localparam int DLY_W   = 32;
    localparam int PROD_W  = COEF_W + DLY_W;
    localparam int SHP_W   = PROD_W - COEF_FRAC_BITS;
    localparam int SUM_W   = SHP_W + 2;
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_NUM   = 5;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_TWO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_ONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_TWO  = 3'd4;

    // Reset value of feed_zero: unity gain.
    localparam logic signed [COEF_W-1:0] FEED_ZERO_RST = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FZ,
        ST_MUL_F1,
        ST_MUL_B1,
        ST_MUL_F2,
        ST_MUL_B2,
        ST_FINISH,
        ST_OUTPUT
    } t_state;

    // Second operand of the shared adder.
    typedef enum logic [1:0] {
        ADD_ZERO,
        ADD_D0,
        ADD_D1,
        ADD_ACC
    } t_add_sel;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] coef_sel;
        logic                 use_y;
        t_add_sel             add_sel;
        logic                 wr_y;
        logic                 wr_acc;
        logic                 wr_d0;
        logic                 wr_d1;
        logic                 next_sec;
        logic                 load_out;
        logic                 sec;
    } t_ctrl;

    // Saturate a sum to the delay width.
    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [SUM_W-1:0] v);
        logic same;
        same = (&v[SUM_W-1:DLY_W-1]) | ~(|v[SUM_W-1:DLY_W-1]);
        if (same) begin
            return v[DLY_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DLY_W-1){1'b1}}};
        end
    endfunction

    // Saturate a section output to the sample width.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [DLY_W-1:0] v);
        logic same;
        same = (&v[DLY_W-1:SAMPLE_BITS-1]) | ~(|v[DLY_W-1:SAMPLE_BITS-1]);
        if (same) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[DLY_W-1]) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

endpackage

/* hw/rtl/cbq_mul.sv */
// Shared registered multiplier with the fixed-point scaling shift.
module cbq_mul (
    input  logic                                i_clk,
    input  logic signed [cbq_pkg::COEF_W-1:0]   i_coef,
    input  logic signed [cbq_pkg::DLY_W-1:0]    i_val,
    output logic signed [cbq_pkg::SHP_W-1:0]    o_prod
);

    logic signed [cbq_pkg::PROD_W-1:0] w_prod;
    logic signed [cbq_pkg::SHP_W-1:0]  r_prod;

    // Full product; dropping the low fraction bits is a floor shift.
    assign w_prod = i_coef * i_val;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[cbq_pkg::PROD_W-1:cbq_pkg::COEF_FRAC_BITS];
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/cbq_seq.sv */
// Sequencer that steps both filter sections through the shared multiplier.
module cbq_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    output logic           o_in_ready,
    output cbq_pkg::t_ctrl o_ctrl
);

    cbq_pkg::t_state r_state, n_state;
    logic            r_sec, n_sec;

    // State and section registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbq_pkg::ST_IDLE;
            r_sec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sec   <= n_sec;
        end
    end

    // Next state and datapath controls.
    always_comb begin
        n_state         = r_state;
        n_sec           = r_sec;
        o_in_ready      = 1'b0;
        o_ctrl          = '0;
        o_ctrl.coef_sel = cbq_pkg::CFG_FEED_ZERO;
        o_ctrl.add_sel  = cbq_pkg::ADD_ZERO;
        o_ctrl.sec      = r_sec;
        case (r_state)
            cbq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = cbq_pkg::ST_MUL_FZ;
                    n_sec   = 1'b0;
                end
            end
            cbq_pkg::ST_MUL_FZ: begin
                o_ctrl.coef_sel = cbq_pkg::CFG_FEED_ZERO;
                n_state         = cbq_pkg::ST_MUL_F1;
            end
            cbq_pkg::ST_MUL_F1: begin
                o_ctrl.coef_sel = cbq_pkg::CFG_FEED_ONE;
                o_ctrl.add_sel  = cbq_pkg::ADD_D0;
                o_ctrl.wr_y     = 1'b1;
                n_state         = cbq_pkg::ST_MUL_B1;
            end
            cbq_pkg::ST_MUL_B1: begin
                o_ctrl.coef_sel = cbq_pkg::CFG_BACK_ONE;
                o_ctrl.use_y    = 1'b1;
                o_ctrl.add_sel  = cbq_pkg::ADD_D1;
                o_ctrl.wr_acc   = 1'b1;
                n_state         = cbq_pkg::ST_MUL_F2;
            end
            cbq_pkg::ST_MUL_F2: begin
                o_ctrl.coef_sel = cbq_pkg::CFG_FEED_TWO;
                o_ctrl.add_sel  = cbq_pkg::ADD_ACC;
                o_ctrl.wr_d0    = 1'b1;
                n_state         = cbq_pkg::ST_MUL_B2;
            end
            cbq_pkg::ST_MUL_B2: begin
                o_ctrl.coef_sel = cbq_pkg::CFG_BACK_TWO;
                o_ctrl.use_y    = 1'b1;
                o_ctrl.add_sel  = cbq_pkg::ADD_ZERO;
                o_ctrl.wr_acc   = 1'b1;
                n_state         = cbq_pkg::ST_FINISH;
            end
            cbq_pkg::ST_FINISH: begin
                o_ctrl.add_sel = cbq_pkg::ADD_ACC;
                o_ctrl.wr_d1   = 1'b1;
                if (!r_sec) begin
                    // First section done: its output feeds the second.
                    o_ctrl.next_sec = 1'b1;
                    n_sec           = 1'b1;
                    n_state         = cbq_pkg::ST_MUL_FZ;
                end else begin
                    n_state = cbq_pkg::ST_OUTPUT;
                end
            end
            cbq_pkg::ST_OUTPUT: begin
                if (i_out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = cbq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/cascaded_biquad_lowpass_top.sv */
// Fourth-order low-pass filter: two biquad sections sharing one multiplier.
//
// Each accepted sample runs through two identical transposed direct form II
// biquad sections that share the five Q3.28 coefficients. All ten products go
// through one 32x32 registered multiplier, one per cycle, and one adder with
// 32-bit saturation forms the section output and the new delays. Each section
// goes through the states MUL_FZ, MUL_F1, MUL_B1, MUL_F2, MUL_B2 and FINISH;
// then OUTPUT loads the output register, and the input is ready again only once
// the sequencer is back in idle, so a new sample is not accepted before the
// last one is finished. A result still held on the output stalls the next load
// until it is taken. Coefficients should be written through the plain write
// port only while the filter is idle; the block itself does not enforce this.
// Writes to indexes 5 to 7 are ignored.
module cascaded_biquad_lowpass_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [cbq_pkg::COEF_W-1:0]            i_cfg_wdata,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [cbq_pkg::TDATA_W-1:0]           s_axis_tdata,  // sample_in, zero pad
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [cbq_pkg::TDATA_W-1:0]           m_axis_tdata   // sample_out, zero pad
);

    logic signed [cbq_pkg::COEF_W-1:0]      r_coef [cbq_pkg::CFG_NUM];
    logic signed [cbq_pkg::DLY_W-1:0]       r_d0 [2];
    logic signed [cbq_pkg::DLY_W-1:0]       r_d1 [2];
    logic signed [cbq_pkg::DLY_W-1:0]       r_x;
    logic signed [cbq_pkg::DLY_W-1:0]       r_y;
    logic signed [cbq_pkg::SUM_W-1:0]       r_acc;
    logic [cbq_pkg::SAMPLE_BITS-1:0]        r_out;
    logic                                   r_out_vld;

    cbq_pkg::t_ctrl                         w_ctrl;
    logic                                   w_in_acc;
    logic                                   w_out_free;
    logic signed [cbq_pkg::COEF_W-1:0]      w_coef;
    logic signed [cbq_pkg::DLY_W-1:0]       w_val;
    logic signed [cbq_pkg::SHP_W-1:0]       w_prod;
    logic signed [cbq_pkg::SUM_W-1:0]       w_addend;
    logic signed [cbq_pkg::SUM_W-1:0]       w_sum;
    logic signed [cbq_pkg::DLY_W-1:0]       w_sat;

    assign w_in_acc   = s_axis_tvalid & s_axis_tready;
    assign w_out_free = ~r_out_vld | m_axis_tready;

    cbq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    // Coefficient and operand selection for the multiplier.
    always_comb begin
        case (w_ctrl.coef_sel)
            cbq_pkg::CFG_FEED_ZERO: w_coef = r_coef[0];
            cbq_pkg::CFG_FEED_ONE:  w_coef = r_coef[1];
            cbq_pkg::CFG_FEED_TWO:  w_coef = r_coef[2];
            cbq_pkg::CFG_BACK_ONE:  w_coef = r_coef[3];
            cbq_pkg::CFG_BACK_TWO:  w_coef = r_coef[4];
            default:                w_coef = r_coef[0];
        endcase
    end

    assign w_val = w_ctrl.use_y ? r_y : r_x;

    cbq_mul u_mul (
        .i_clk  (i_clk),
        .i_coef (w_coef),
        .i_val  (w_val),
        .o_prod (w_prod)
    );

    // Shared adder: registered product plus a delay, the accumulator or zero.
    always_comb begin
        case (w_ctrl.add_sel)
            cbq_pkg::ADD_D0:  w_addend = cbq_pkg::SUM_W'(r_d0[w_ctrl.sec]);
            cbq_pkg::ADD_D1:  w_addend = cbq_pkg::SUM_W'(r_d1[w_ctrl.sec]);
            cbq_pkg::ADD_ACC: w_addend = r_acc;
            default:          w_addend = '0;
        endcase
    end

    assign w_sum = cbq_pkg::SUM_W'(w_prod) + w_addend;
    assign w_sat = cbq_pkg::sat_dly(w_sum);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= cbq_pkg::FEED_ZERO_RST;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                cbq_pkg::CFG_FEED_ZERO: r_coef[0] <= i_cfg_wdata;
                cbq_pkg::CFG_FEED_ONE:  r_coef[1] <= i_cfg_wdata;
                cbq_pkg::CFG_FEED_TWO:  r_coef[2] <= i_cfg_wdata;
                cbq_pkg::CFG_BACK_ONE:  r_coef[3] <= i_cfg_wdata;
                cbq_pkg::CFG_BACK_TWO:  r_coef[4] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Section delay registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0[0] <= '0;
            r_d0[1] <= '0;
            r_d1[0] <= '0;
            r_d1[1] <= '0;
        end else begin
            if (w_ctrl.wr_d0) begin
                r_d0[w_ctrl.sec] <= w_sat;
            end
            if (w_ctrl.wr_d1) begin
                r_d1[w_ctrl.sec] <= w_sat;
            end
        end
    end

    // Section input, section output and partial sum.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= cbq_pkg::DLY_W'(signed'(s_axis_tdata[cbq_pkg::SAMPLE_BITS-1:0]));
        end else if (w_ctrl.next_sec) begin
            r_x <= r_y;
        end
        if (w_ctrl.wr_y) begin
            r_y <= w_sat;
        end
        if (w_ctrl.wr_acc) begin
            r_acc <= w_sum;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            r_out <= cbq_pkg::sat_smp(r_y);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = cbq_pkg::TDATA_W'(r_out);

endmodule
